// ===== hw/rtl/srdz_pkg.sv =====
// Shared types and constants for the stick radial dead zone block.
package srdz_pkg;

	localparam int ZONE_BITS     = 15;
	localparam int GAIN_BITS     = 16;
	localparam int GAIN_FRAC     = 8;
	localparam int CFG_ADDR_BITS = 3;
	localparam int CFG_DATA_BITS = 16;
	localparam logic [GAIN_BITS-1:0] GAIN_RESET = 16'd256;

	typedef enum logic [CFG_ADDR_BITS-1:0] {
		REG_AXIS_ENABLE     = 3'd0,
		REG_USE_LEFT_STICK  = 3'd1,
		REG_INNER_ZONE      = 3'd2,
		REG_OUTER_ZONE      = 3'd3,
		REG_INVERT_VERTICAL = 3'd4,
		REG_GAIN            = 3'd5
	} reg_idx_t;

	typedef struct packed {
		logic                 axis_enable;
		logic                 use_left_stick;
		logic [ZONE_BITS-1:0] inner_zone;
		logic [ZONE_BITS-1:0] outer_zone;
		logic                 invert_vertical;
		logic [GAIN_BITS-1:0] gain;
	} cfg_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_SQUARE,
		ST_SQRT_INIT,
		ST_SQRT_RUN,
		ST_CHECK,
		ST_NM_RUN,
		ST_NM_TAKE,
		ST_COMP_MUL,
		ST_COMP_INIT,
		ST_COMP_RUN,
		ST_GAIN,
		ST_DONE
	} state_t;

	typedef struct packed {
		logic load;
		logic square;
		logic sqrt_start;
		logic sqrt_step;
		logic check;
		logic nm_start;
		logic div_step;
		logic nm_take;
		logic comp_mul;
		logic comp_start;
		logic gain_mul;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic cfg_ok;
		logic mag_gt_inner;
		logic d_ge_range;
	} sts_t;

endpackage

// ===== hw/rtl/stick_radial_dead_zone.sv =====
// Top level of the stick radial dead zone: ports, config registers, control and datapath.
//
// Usage:
//  - s_* input stream: one transfer carries a sample of both sticks; s_tuser is
//    the device-present flag. Held when no device is present.
//  - m_* output stream: one transfer per input item with the conditioned
//    vector and the held raw vector it was computed from.
//  - cfg_we/cfg_addr/cfg_wdata: register writes, taken on any edge with
//    cfg_we high; change them only while the block is idle.
//  - Sequence: a full rescale runs the square, the bit-serial root, the
//    bit-serial normalize divide, the component multiply and bit-serial
//    divide, then the gain multiply. An item whose rescaled magnitude caps at full scale
//    skips the normalize divide; one inside the inner zone stops after the
//    root; a disabled block or invalid zone bypasses the datapath.
//  - Flow: one item at a time, s_tready high only between items; a new item
//    is taken only after the last one is loaded into the output register.
//  - Output register: a finished result waits in it while the next item is
//    taken and worked on; the next result stalls only if m_tready stays low.
//  - Reset: arst_n clears the controller, output valid and held input sample; the
//    registers return to disabled, left stick, zones zero, no inversion, gain 1.0.
module stick_radial_dead_zone #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  logic                                  s_tvalid,
	output logic                                  s_tready,
	// left_x, left_y, right_x, right_y (lowest first), zero padded to bytes
	input  logic [((4*SAMPLE_BITS+7)/8)*8-1:0]    s_tdata,
	// device_present
	input  logic                                  s_tuser,
	output logic                                  m_tvalid,
	input  logic                                  m_tready,
	// out_x, out_y, held_raw_x, held_raw_y (lowest first), zero padded to bytes
	output logic [((4*SAMPLE_BITS+7)/8)*8-1:0]    m_tdata,
	input  logic                                  cfg_we,
	input  logic [srdz_pkg::CFG_ADDR_BITS-1:0]    cfg_addr,
	input  logic [srdz_pkg::CFG_DATA_BITS-1:0]    cfg_wdata
);

	localparam int N         = SAMPLE_BITS;
	localparam int TdataBits = ((4 * N + 7) / 8) * 8;

	srdz_pkg::cfg_t cfg_q;
	srdz_pkg::cmd_t cmd;
	srdz_pkg::sts_t sts;

	logic signed [N-1:0] left_x, left_y, right_x, right_y;
	logic signed [N-1:0] out_x, out_y, held_raw_x, held_raw_y;

	// register file; out-of-range indexes fall through
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.axis_enable     <= 1'b0;
			cfg_q.use_left_stick  <= 1'b1;
			cfg_q.inner_zone      <= '0;
			cfg_q.outer_zone      <= '0;
			cfg_q.invert_vertical <= 1'b0;
			cfg_q.gain            <= srdz_pkg::GAIN_RESET;
		end else if (cfg_we) begin
			case (srdz_pkg::reg_idx_t'(cfg_addr))
				srdz_pkg::REG_AXIS_ENABLE:     cfg_q.axis_enable     <= cfg_wdata[0];
				srdz_pkg::REG_USE_LEFT_STICK:  cfg_q.use_left_stick  <= cfg_wdata[0];
				srdz_pkg::REG_INNER_ZONE:
					cfg_q.inner_zone <= cfg_wdata[srdz_pkg::ZONE_BITS-1:0];
				srdz_pkg::REG_OUTER_ZONE:
					cfg_q.outer_zone <= cfg_wdata[srdz_pkg::ZONE_BITS-1:0];
				srdz_pkg::REG_INVERT_VERTICAL: cfg_q.invert_vertical <= cfg_wdata[0];
				srdz_pkg::REG_GAIN:
					cfg_q.gain <= cfg_wdata[srdz_pkg::GAIN_BITS-1:0];
				default: ;
			endcase
		end
	end

	// unpack the input transfer
	assign left_x  = s_tdata[N-1:0];
	assign left_y  = s_tdata[2*N-1:N];
	assign right_x = s_tdata[3*N-1:2*N];
	assign right_y = s_tdata[4*N-1:3*N];

	srdz_ctrl #(.SAMPLE_BITS(N)) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	srdz_dp #(.SAMPLE_BITS(N)) u_dp (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg            (cfg_q),
		.cmd            (cmd),
		.sts            (sts),
		.device_present (s_tuser),
		.left_x         (left_x),
		.left_y         (left_y),
		.right_x        (right_x),
		.right_y        (right_y),
		.out_x          (out_x),
		.out_y          (out_y),
		.held_raw_x     (held_raw_x),
		.held_raw_y     (held_raw_y)
	);

	// pack the output transfer, zero filled at the top
	assign m_tdata = TdataBits'({held_raw_y, held_raw_x, out_y, out_x});

endmodule

// ===== hw/rtl/srdz_isqrt.sv =====
// Bit-serial integer square root, one root bit per step.
module srdz_isqrt #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                       clk,
	input  logic                       start,
	input  logic                       step,
	input  logic [2*SAMPLE_BITS-1:0]   radicand,
	output logic [SAMPLE_BITS-1:0]     root
);

	localparam int RemBits = SAMPLE_BITS + 3;

	logic [2*SAMPLE_BITS-1:0] op_q;
	logic [RemBits-1:0]       rem_q;
	logic [SAMPLE_BITS-1:0]   root_q;
	logic [RemBits-1:0]       rem_sh;
	logic [RemBits-1:0]       trial;

	// bring down the next two radicand bits, trial = 4*root + 1
	assign rem_sh = {rem_q[RemBits-3:0], op_q[2*SAMPLE_BITS-1 -: 2]};
	assign trial  = {{(RemBits-SAMPLE_BITS-2){1'b0}}, root_q, 2'b01};

	always_ff @(posedge clk) begin
		if (start) begin
			op_q   <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (step) begin
			op_q <= {op_q[2*SAMPLE_BITS-3:0], 2'b00};
			if (rem_sh >= trial) begin
				rem_q  <= rem_sh - trial;
				root_q <= {root_q[SAMPLE_BITS-2:0], 1'b1};
			end else begin
				rem_q  <= rem_sh;
				root_q <= {root_q[SAMPLE_BITS-2:0], 1'b0};
			end
		end
	end

	assign root = root_q;

endmodule

// ===== hw/rtl/srdz_div.sv =====
// Restoring divider, one quotient bit per step; caller keeps quotient in range.
module srdz_div #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                   clk,
	input  logic                   start,
	input  logic                   step,
	input  logic [SAMPLE_BITS-1:0] rem_init,
	input  logic [SAMPLE_BITS-1:0] lo_init,
	input  logic [SAMPLE_BITS-1:0] divisor,
	output logic [SAMPLE_BITS-1:0] quotient
);

	logic [SAMPLE_BITS-1:0] rem_q;
	logic [SAMPLE_BITS-1:0] lo_q;
	logic [SAMPLE_BITS-1:0] dvs_q;
	logic [SAMPLE_BITS:0]   trial;
	logic [SAMPLE_BITS:0]   diff;

	assign trial = {rem_q, lo_q[SAMPLE_BITS-1]};
	assign diff  = trial - {1'b0, dvs_q};

	// lo_q shifts the dividend out and the quotient bits in
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= rem_init;
			lo_q  <= lo_init;
			dvs_q <= divisor;
		end else if (step) begin
			if (trial >= {1'b0, dvs_q}) begin
				rem_q <= diff[SAMPLE_BITS-1:0];
				lo_q  <= {lo_q[SAMPLE_BITS-2:0], 1'b1};
			end else begin
				rem_q <= trial[SAMPLE_BITS-1:0];
				lo_q  <= {lo_q[SAMPLE_BITS-2:0], 1'b0};
			end
		end
	end

	assign quotient = lo_q;

endmodule

// ===== hw/rtl/srdz_dp.sv =====
// Datapath: held sample, squaring, root, rescale divides, gain and output registers.
module srdz_dp #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  srdz_pkg::cfg_t                cfg,
	input  srdz_pkg::cmd_t                cmd,
	output srdz_pkg::sts_t                sts,
	input  logic                          device_present,
	input  logic signed [SAMPLE_BITS-1:0] left_x,
	input  logic signed [SAMPLE_BITS-1:0] left_y,
	input  logic signed [SAMPLE_BITS-1:0] right_x,
	input  logic signed [SAMPLE_BITS-1:0] right_y,
	output logic signed [SAMPLE_BITS-1:0] out_x,
	output logic signed [SAMPLE_BITS-1:0] out_y,
	output logic signed [SAMPLE_BITS-1:0] held_raw_x,
	output logic signed [SAMPLE_BITS-1:0] held_raw_y
);

	localparam int N  = SAMPLE_BITS;
	localparam int ZB = srdz_pkg::ZONE_BITS;
	localparam int GB = srdz_pkg::GAIN_BITS;
	localparam int BW = (N + 1 > GB + 1) ? N + 1 : GB + 1;
	localparam int PW = N + 1 + BW;
	localparam logic [N-1:0] Full = {1'b1, {(N-1){1'b0}}};
	localparam logic signed [PW-1:0] SatHi = PW'((1 << (N - 1)) - 1);
	localparam logic signed [PW-1:0] SatLo = PW'(-(1 << (N - 1)));

	logic signed [N-1:0]  raw_x_q, raw_y_q;
	logic                 zero_q;
	logic [N-1:0]         range_q;
	logic [N-1:0]         newmag_q;
	logic signed [PW-1:0] mul_x_q, mul_y_q;
	logic signed [N-1:0]  out_x_q, out_y_q, held_x_q, held_y_q;

	logic [ZB:0]          zone_sum;
	logic [ZB+N-2:0]      inner_wide, outer_wide;
	logic [N-2:0]         inner_s, outer_s;
	logic [N-1:0]         abs_x, abs_y;
	logic signed [N:0]    mx_a, my_a;
	logic signed [BW-1:0] mx_b, my_b;
	logic [2*N-1:0]       radicand;
	logic [N-1:0]         mag;
	logic [N-1:0]         excess;
	logic                 div_start;
	logic [N-1:0]         rem_init_x, rem_init_y, lo_init_x, lo_init_y, divisor;
	logic [N-1:0]         quo_x, quo_y;
	logic [N:0]           qx_ext, qy_ext;
	logic signed [N:0]    vx, vy;
	logic                 neg_y;

	function automatic logic [N-1:0] scale_sat(input logic signed [PW-1:0] p);
		logic signed [PW-1:0] sh;
		sh = p >>> srdz_pkg::GAIN_FRAC;
		// truncate toward zero
		if (p[PW-1] && (p[srdz_pkg::GAIN_FRAC-1:0] != '0))
			sh = sh + {{(PW-1){1'b0}}, 1'b1};
		if (sh > SatHi)
			return SatHi[N-1:0];
		else if (sh < SatLo)
			return SatLo[N-1:0];
		else
			return sh[N-1:0];
	endfunction

	// zones in sample scale: (z << (N-1)) >> 15
	assign zone_sum   = {1'b0, cfg.inner_zone} + {1'b0, cfg.outer_zone};
	assign inner_wide = {cfg.inner_zone, {(N-1){1'b0}}};
	assign outer_wide = {cfg.outer_zone, {(N-1){1'b0}}};
	assign inner_s    = inner_wide[ZB+N-2 -: N-1];
	assign outer_s    = outer_wide[ZB+N-2 -: N-1];

	assign sts.cfg_ok       = cfg.axis_enable && !zone_sum[ZB];
	assign sts.mag_gt_inner = mag > {1'b0, inner_s};
	assign excess           = mag - {1'b0, inner_s};
	assign sts.d_ge_range   = excess >= range_q;

	assign abs_x = raw_x_q[N-1] ? (~raw_x_q + 1'b1) : raw_x_q;
	assign abs_y = raw_y_q[N-1] ? (~raw_y_q + 1'b1) : raw_y_q;

	// held raw value is architectural state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			raw_x_q <= '0;
			raw_y_q <= '0;
		end else if (cmd.load) begin
			if (!sts.cfg_ok) begin
				raw_x_q <= '0;
				raw_y_q <= '0;
			end else if (device_present) begin
				raw_x_q <= cfg.use_left_stick ? left_x : right_x;
				raw_y_q <= cfg.use_left_stick ? left_y : right_y;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			zero_q  <= !sts.cfg_ok;
			range_q <= Full - {1'b0, inner_s} - {1'b0, outer_s};
		end else if (cmd.check) begin
			zero_q <= zero_q | !sts.mag_gt_inner;
		end
		if (cmd.check)
			newmag_q <= Full;
		else if (cmd.nm_take)
			newmag_q <= quo_x;
	end

	// sign applied after the unsigned divide; vertical inversion folds in here
	assign neg_y  = raw_y_q[N-1] ^ cfg.invert_vertical;
	assign qx_ext = {1'b0, quo_x};
	assign qy_ext = {1'b0, quo_y};
	assign vx     = raw_x_q[N-1] ? (~qx_ext + 1'b1) : qx_ext;
	assign vy     = neg_y ? (~qy_ext + 1'b1) : qy_ext;

	// one multiplier per lane, operands picked by phase
	always_comb begin
		mx_a = '0;
		mx_b = '0;
		my_a = '0;
		my_b = '0;
		if (cmd.square) begin
			mx_a = {raw_x_q[N-1], raw_x_q};
			mx_b = {{(BW-N){raw_x_q[N-1]}}, raw_x_q};
			my_a = {raw_y_q[N-1], raw_y_q};
			my_b = {{(BW-N){raw_y_q[N-1]}}, raw_y_q};
		end else if (cmd.comp_mul) begin
			mx_a = {1'b0, abs_x};
			mx_b = {{(BW-N){1'b0}}, newmag_q};
			my_a = {1'b0, abs_y};
			my_b = {{(BW-N){1'b0}}, newmag_q};
		end else if (cmd.gain_mul) begin
			mx_a = vx;
			mx_b = {{(BW-GB){1'b0}}, cfg.gain};
			my_a = vy;
			my_b = {{(BW-GB){1'b0}}, cfg.gain};
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.square || cmd.comp_mul || cmd.gain_mul) begin
			mul_x_q <= mx_a * mx_b;
			mul_y_q <= my_a * my_b;
		end
	end

	assign radicand = mul_x_q[2*N-1:0] + mul_y_q[2*N-1:0];

	srdz_isqrt #(.SAMPLE_BITS(N)) u_isqrt (
		.clk      (clk),
		.start    (cmd.sqrt_start),
		.step     (cmd.sqrt_step),
		.radicand (radicand),
		.root     (mag)
	);

	// normalize divide: excess << (N-1) / range, excess < range so N-1 bits
	// component divide: |raw| * newmag / mag, quotient <= full scale
	assign div_start  = cmd.nm_start | cmd.comp_start;
	assign divisor    = cmd.nm_start ? range_q : mag;
	assign rem_init_x = cmd.nm_start ? excess : mul_x_q[2*N-1:N];
	assign lo_init_x  = cmd.nm_start ? '0 : mul_x_q[N-1:0];
	assign rem_init_y = cmd.nm_start ? excess : mul_y_q[2*N-1:N];
	assign lo_init_y  = cmd.nm_start ? '0 : mul_y_q[N-1:0];

	srdz_div #(.SAMPLE_BITS(N)) u_div_x (
		.clk      (clk),
		.start    (div_start),
		.step     (cmd.div_step),
		.rem_init (rem_init_x),
		.lo_init  (lo_init_x),
		.divisor  (divisor),
		.quotient (quo_x)
	);

	srdz_div #(.SAMPLE_BITS(N)) u_div_y (
		.clk      (clk),
		.start    (div_start),
		.step     (cmd.div_step),
		.rem_init (rem_init_y),
		.lo_init  (lo_init_y),
		.divisor  (divisor),
		.quotient (quo_y)
	);

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_x_q  <= zero_q ? '0 : scale_sat(mul_x_q);
			out_y_q  <= zero_q ? '0 : scale_sat(mul_y_q);
			held_x_q <= raw_x_q;
			held_y_q <= raw_y_q;
		end
	end

	assign out_x      = out_x_q;
	assign out_y      = out_y_q;
	assign held_raw_x = held_x_q;
	assign held_raw_y = held_y_q;

endmodule

// ===== hw/rtl/srdz_ctrl.sv =====
// Controller: sequences one item through the datapath and owns the handshakes.
module srdz_ctrl #(
	parameter int SAMPLE_BITS = 16
) (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           s_tvalid,
	output logic           s_tready,
	output logic           m_tvalid,
	input  logic           m_tready,
	input  srdz_pkg::sts_t sts,
	output srdz_pkg::cmd_t cmd
);

	localparam int CntBits = $clog2(SAMPLE_BITS);

	srdz_pkg::state_t state_q, state_d;
	logic [CntBits-1:0] cnt_q;
	logic               out_valid_q;
	logic               out_free;

	assign out_free = !out_valid_q || m_tready;

	always_comb begin
		state_d = state_q;
		case (state_q)
			srdz_pkg::ST_IDLE: begin
				if (s_tvalid)
					state_d = sts.cfg_ok ? srdz_pkg::ST_SQUARE : srdz_pkg::ST_DONE;
			end
			srdz_pkg::ST_SQUARE:    state_d = srdz_pkg::ST_SQRT_INIT;
			srdz_pkg::ST_SQRT_INIT: state_d = srdz_pkg::ST_SQRT_RUN;
			srdz_pkg::ST_SQRT_RUN: begin
				if (cnt_q == '0)
					state_d = srdz_pkg::ST_CHECK;
			end
			srdz_pkg::ST_CHECK: begin
				if (!sts.mag_gt_inner)
					state_d = srdz_pkg::ST_DONE;
				else if (sts.d_ge_range)
					state_d = srdz_pkg::ST_COMP_MUL;
				else
					state_d = srdz_pkg::ST_NM_RUN;
			end
			srdz_pkg::ST_NM_RUN: begin
				if (cnt_q == '0)
					state_d = srdz_pkg::ST_NM_TAKE;
			end
			srdz_pkg::ST_NM_TAKE:   state_d = srdz_pkg::ST_COMP_MUL;
			srdz_pkg::ST_COMP_MUL:  state_d = srdz_pkg::ST_COMP_INIT;
			srdz_pkg::ST_COMP_INIT: state_d = srdz_pkg::ST_COMP_RUN;
			srdz_pkg::ST_COMP_RUN: begin
				if (cnt_q == '0)
					state_d = srdz_pkg::ST_GAIN;
			end
			srdz_pkg::ST_GAIN:      state_d = srdz_pkg::ST_DONE;
			srdz_pkg::ST_DONE: begin
				if (out_free)
					state_d = srdz_pkg::ST_IDLE;
			end
			default:                state_d = srdz_pkg::ST_IDLE;
		endcase
	end

	always_comb begin
		cmd      = '0;
		s_tready = 1'b0;
		case (state_q)
			srdz_pkg::ST_IDLE: begin
				s_tready = 1'b1;
				cmd.load = s_tvalid;
			end
			srdz_pkg::ST_SQUARE:    cmd.square     = 1'b1;
			srdz_pkg::ST_SQRT_INIT: cmd.sqrt_start = 1'b1;
			srdz_pkg::ST_SQRT_RUN:  cmd.sqrt_step  = 1'b1;
			srdz_pkg::ST_CHECK: begin
				cmd.check    = 1'b1;
				cmd.nm_start = sts.mag_gt_inner && !sts.d_ge_range;
			end
			srdz_pkg::ST_NM_RUN:    cmd.div_step   = 1'b1;
			srdz_pkg::ST_NM_TAKE:   cmd.nm_take    = 1'b1;
			srdz_pkg::ST_COMP_MUL:  cmd.comp_mul   = 1'b1;
			srdz_pkg::ST_COMP_INIT: cmd.comp_start = 1'b1;
			srdz_pkg::ST_COMP_RUN:  cmd.div_step   = 1'b1;
			srdz_pkg::ST_GAIN:      cmd.gain_mul   = 1'b1;
			srdz_pkg::ST_DONE:      cmd.out_load   = out_free;
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= srdz_pkg::ST_IDLE;
			cnt_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			case (state_q)
				srdz_pkg::ST_SQRT_INIT: cnt_q <= CntBits'(SAMPLE_BITS - 1);
				srdz_pkg::ST_CHECK:     cnt_q <= CntBits'(SAMPLE_BITS - 2);
				srdz_pkg::ST_COMP_INIT: cnt_q <= CntBits'(SAMPLE_BITS - 1);
				srdz_pkg::ST_SQRT_RUN,
				srdz_pkg::ST_NM_RUN,
				srdz_pkg::ST_COMP_RUN:  cnt_q <= cnt_q - 1'b1;
				default: ;
			endcase
			if (cmd.out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	assign m_tvalid = out_valid_q;

	a_load_into_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || m_tready))
		else $error("result loaded over a pending transfer");

	a_disabled_short: assert property (@(posedge clk) disable iff (!arst_n)
		(s_tvalid && s_tready && !sts.cfg_ok) |=> (state_q == srdz_pkg::ST_DONE))
		else $error("disabled item did not bypass the datapath");

	a_inside_zone: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == srdz_pkg::ST_CHECK && !sts.mag_gt_inner)
			|=> (state_q == srdz_pkg::ST_DONE))
		else $error("item inside inner zone was rescaled");

	a_nm_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.nm_start |-> (cmd.check && sts.mag_gt_inner))
		else $error("normalize divide started outside the live ring");

endmodule
